// ===== rtl/core/scm_pkg.sv =====
// Shared constants and types for the sprite column move block.
package scm_pkg;

   // Column geometry and sprite limits
   localparam int COLUMN_ROWS     = 96;
   localparam int MAX_SPRITE_ROWS = 32;

   // Derived widths
   localparam int ROW_ADDR_W  = $clog2(COLUMN_ROWS);
   localparam int CNT_W       = $clog2(MAX_SPRITE_ROWS + 1);
   localparam int POS_W       = 10;
   localparam int DATA_W      = 8;
   localparam int ROW_W       = 8;
   localparam int READ_ROW_W  = 7;
   localparam int HEIGHT_W    = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int BITMAP_REGS = 4;
   localparam int WIDE_W      = 16;

   // Request opcodes
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPRITE_HEIGHT = 3'd0,
      CSR_BITMAP_0      = 3'd1,
      CSR_BITMAP_1      = 3'd2,
      CSR_BITMAP_2      = 3'd3,
      CSR_BITMAP_3      = 3'd4
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW,
      ST_READ,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/scm_req_if.sv =====
// Request channel: valid/ready handshake with move and read fields.
interface scm_req_if;
   import scm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [ROW_W-1:0]      new_row;
   logic                         force_req;
   logic        [READ_ROW_W-1:0] read_row;

   modport source (output valid, output op, output new_row, output force_req,
                   output read_row, input ready);
   modport sink   (input valid, input op, input new_row, input force_req,
                   input read_row, output ready);
endinterface

// ===== rtl/core/scm_rsp_if.sv =====
// Response channel: valid/ready handshake with row data and move flag.
interface scm_rsp_if;
   import scm_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] row_data;
   logic              moved;

   modport source (output valid, output row_data, output moved, input ready);
   modport sink   (input valid, input row_data, input moved, output ready);
endinterface

// ===== rtl/core/sprite_column_move_with_clipping.sv =====
// A read goes via ST_READ and ST_FINISH to its response; a move walks ST_CLEAR and ST_DRAW
// over h rows each, where h is the sprite height clamped to 32, one column write per cycle
// through one adder. A skipped move (same row, no force) goes straight to ST_FINISH. One item
// is in work at a time; a finished response may wait in the output register while the next
// request is taken. Reset (synchronous, active high) clears the column to zero through per-row
// valid bits, the sprite position and all configuration registers; no clearing pass is needed.
module sprite_column_move_with_clipping (
   input  logic                               clock,
   input  logic                               reset,
   scm_req_if.sink                            req_chan,
   scm_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [scm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [scm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import scm_pkg::*;

   // Configuration registers
   logic [HEIGHT_W-1:0]   height_ff;
   logic [CSR_DATA_W-1:0] bitmap_ff [BITMAP_REGS];

   // Sequencer and working registers
   state_type                   state_ff, state_in;
   logic signed [ROW_W-1:0]     current_row_ff, current_row_in;
   logic signed [ROW_W-1:0]     target_ff, target_in;
   logic        [CNT_W-1:0]     cnt_ff, cnt_in;
   logic        [CNT_W-1:0]     h_ff, h_in;
   logic                        is_read_ff, is_read_in;
   logic                        moved_res_ff, moved_res_in;
   logic        [ROW_ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic                        rd_ok_ff, rd_ok_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_moved_ff, rsp_moved_in;

   // Column memory with per-row valid bits
   logic [DATA_W-1:0]      column_mem [COLUMN_ROWS];
   logic [COLUMN_ROWS-1:0] row_valid_ff;
   logic [DATA_W-1:0]      mem_q_ff;
   logic                   valid_q_ff;

   // Shared position unit
   logic signed [ROW_W-1:0] base_row;
   logic signed [POS_W-1:0] pos;
   logic                    pos_in_range;
   logic                    last_step;
   logic                    mem_we;
   logic [ROW_ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]       wr_data;
   logic [DATA_W-1:0]       bitmap_byte;
   logic [CNT_W-1:0]        h_eff;
   logic [WIDE_W-1:0]       rd_wide;
   logic                    req_xfer;
   logic                    out_free;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= '0;
         for (int k = 0; k < BITMAP_REGS; k++) begin
            bitmap_ff[k] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_SPRITE_HEIGHT: begin
               height_ff <= csr_wdata[HEIGHT_W-1:0];
            end
            CSR_BITMAP_0, CSR_BITMAP_1, CSR_BITMAP_2, CSR_BITMAP_3: begin
               bitmap_ff[2'(csr_index - CSR_BITMAP_0)] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Height clamp and read address decode
   always_comb begin
      if (height_ff > HEIGHT_W'(MAX_SPRITE_ROWS)) begin
         h_eff = CNT_W'(MAX_SPRITE_ROWS);
      end else begin
         h_eff = CNT_W'(height_ff);
      end
      rd_wide = WIDE_W'(req_chan.read_row);
   end

   // Shared adder: row under the counter, clipped to the column
   always_comb begin
      base_row     = (state_ff == ST_CLEAR) ? current_row_ff : target_ff;
      pos          = POS_W'(base_row) + $signed(POS_W'(cnt_ff));
      pos_in_range = (pos >= 0) && (pos < POS_W'(COLUMN_ROWS));
      last_step    = (cnt_ff == h_ff - CNT_W'(1));
      bitmap_byte  = bitmap_ff[cnt_ff[4:3]][{cnt_ff[2:0], 3'b000} +: DATA_W];
      wr_addr      = pos[ROW_ADDR_W-1:0];
   end

   // Sequencer next state and outputs
   always_comb begin
      state_in       = state_ff;
      current_row_in = current_row_ff;
      target_in      = target_ff;
      cnt_in         = cnt_ff;
      h_in           = h_ff;
      is_read_in     = is_read_ff;
      moved_res_in   = moved_res_ff;
      rd_addr_in     = rd_addr_ff;
      rd_ok_in       = rd_ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;
      rsp_moved_in   = rsp_moved_ff;
      mem_we         = 1'b0;
      wr_data        = '0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               target_in  = req_chan.new_row;
               rd_addr_in = rd_wide[ROW_ADDR_W-1:0];
               rd_ok_in   = rd_wide < WIDE_W'(COLUMN_ROWS);
               h_in       = h_eff;
               cnt_in     = '0;
               if (req_chan.op == OP_READ) begin
                  is_read_in   = 1'b1;
                  moved_res_in = 1'b0;
                  state_in     = ST_READ;
               end else begin
                  is_read_in = 1'b0;
                  if (req_chan.new_row == current_row_ff && !req_chan.force_req) begin
                     moved_res_in = 1'b0;
                     state_in     = ST_FINISH;
                  end else begin
                     moved_res_in = 1'b1;
                     if (h_eff == '0) begin
                        current_row_in = req_chan.new_row;
                        state_in       = ST_FINISH;
                     end else begin
                        state_in = ST_CLEAR;
                     end
                  end
               end
            end
         end
         ST_CLEAR: begin
            mem_we  = pos_in_range;
            wr_data = '0;
            if (last_step) begin
               cnt_in   = '0;
               state_in = ST_DRAW;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAW: begin
            mem_we  = pos_in_range;
            wr_data = bitmap_byte;
            if (last_step) begin
               current_row_in = target_ff;
               state_in       = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_READ: begin
            // registered memory read completes at the end of this cycle
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_moved_in = moved_res_ff;
               if (is_read_ff && rd_ok_ff && valid_q_ff) begin
                  rsp_data_in = mem_q_ff;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         current_row_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         row_valid_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         current_row_ff <= current_row_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (mem_we) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      cnt_ff       <= cnt_in;
      h_ff         <= h_in;
      is_read_ff   <= is_read_in;
      moved_res_ff <= moved_res_in;
      rd_addr_ff   <= rd_addr_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_moved_ff <= rsp_moved_in;
      valid_q_ff   <= row_valid_ff[rd_addr_ff];
   end

   // Column memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         column_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= column_mem[rd_addr_ff];
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.row_data = rsp_data_ff;
   assign rsp_chan.moved    = rsp_moved_ff;

`ifndef SYNTHESIS
   // Column writes only happen while clearing or drawing
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_DRAW))
      else $error("column write outside clear/draw");

   // One item at a time: no request taken in the cycle after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("request accepted while busy");

   // Reads never report a move, moves never carry row data
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.moved && rsp_chan.row_data != '0))
      else $error("response carries both data and move");

   // Step counter stays below the clamped height while walking rows
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_DRAW) |-> (cnt_ff < h_ff))
      else $error("row counter past sprite height");

   // A pending response is never overwritten before it is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(rsp_data_ff))
      else $error("pending response overwritten");
`endif

endmodule

// ===== sim/tb_sprite_column_move_with_clipping.sv =====
// Self-checking testbench for the sprite column move block with clipping.
`timescale 1ns / 1ps

module tb_sprite_column_move_with_clipping;
   import scm_pkg::*;

   localparam int READ_ROW_MAX = (1 << READ_ROW_W) - 1;
   localparam int HEIGHT_MAX   = (1 << HEIGHT_W) - 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP = '1;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 160;
   localparam int DRAIN_CYCLES = 80;

   typedef enum logic {ENTRY_ITEM, ENTRY_CSR} entry_kind_type;

   typedef struct packed {
      logic                    op;
      logic signed [ROW_W-1:0] new_row;
      logic                    force_req;
      logic [READ_ROW_W-1:0]   read_row;
   } column_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] row_data;
      logic              moved;
   } column_result_type;

   typedef struct packed {
      entry_kind_type           kind;
      column_req_type           req;
      logic                     has_exp;
      column_result_type        exp;
      logic [CSR_INDEX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]    csr_data;
   } dir_entry_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   scm_req_if req_chan ();
   scm_rsp_if rsp_chan ();

   sprite_column_move_with_clipping dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the column, sprite position and registers
   logic [DATA_W-1:0]       column_img [COLUMN_ROWS];
   logic signed [ROW_W-1:0] sprite_top;
   logic [HEIGHT_W-1:0]     height_reg;
   logic [CSR_DATA_W-1:0]   bitmap_reg [BITMAP_REGS];

   column_result_type pending_results[$];
   dir_entry_type     directed[$];
   int                mismatch_count = 0;
   int                stall_left = 0;
   logic              quiet_phase = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: report a failure if the run has not finished by the end of this delay
   initial begin
      #15_000_000;
      $display("** sprite_column_move_with_clipping: FAILED **");
      $finish;
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 80))
                                         : int'($urandom_range(1, 3));
   endfunction

   // Predicted result of one item; moves update the shadow column
   function automatic column_result_type apply_column_item(input column_req_type item);
      column_result_type res;
      int old_top, new_top, rows, k, pos;
      res = '0;
      if (item.op == OP_READ) begin
         if (item.read_row < COLUMN_ROWS)
            res.row_data = column_img[item.read_row];
         return res;
      end
      old_top = sprite_top;
      new_top = $signed(item.new_row);
      rows    = (height_reg > MAX_SPRITE_ROWS) ? MAX_SPRITE_ROWS : int'(height_reg);
      if (new_top == old_top && !item.force_req)
         return res;
      // erase with the height in force now, then draw; off-column rows are dropped
      for (k = 0; k < rows; k++) begin
         pos = old_top + k;
         if (pos >= 0 && pos < COLUMN_ROWS)
            column_img[pos] = '0;
      end
      for (k = 0; k < rows; k++) begin
         pos = new_top + k;
         if (pos >= 0 && pos < COLUMN_ROWS)
            column_img[pos] = bitmap_reg[k / 8][(k % 8) * 8 +: 8];
      end
      sprite_top = item.new_row;
      res.moved  = 1'b1;
      return res;
   endfunction

   function automatic column_req_type random_item();
      column_req_type item;
      int pick;
      item.op        = ($urandom_range(0, 99) < 55) ? OP_MOVE : OP_READ;
      item.force_req = 1'($urandom_range(0, 1));
      item.read_row  = ($urandom_range(0, 7) == 0)
                       ? READ_ROW_W'($urandom_range(COLUMN_ROWS, READ_ROW_MAX))
                       : READ_ROW_W'($urandom_range(0, COLUMN_ROWS - 1));
      pick = int'($urandom_range(0, 9));
      // same row often, to hit skipped and forced redraws
      if (pick < 2)
         item.new_row = sprite_top;
      else if (pick < 8)
         item.new_row = ROW_W'(int'($urandom_range(0, 140)) - 40);
      else
         item.new_row = ROW_W'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic dir_entry_type item_row(logic op, int new_row, logic force_req,
                                              int read_row);
      dir_entry_type e;
      e = '0;
      e.kind          = ENTRY_ITEM;
      e.req.op        = op;
      e.req.new_row   = ROW_W'(new_row);
      e.req.force_req = force_req;
      e.req.read_row  = READ_ROW_W'(read_row);
      return e;
   endfunction

   function automatic dir_entry_type checked_row(logic op, int new_row, logic force_req,
                                                 int read_row, int exp_data, logic exp_moved);
      dir_entry_type e;
      e = item_row(op, new_row, force_req, read_row);
      e.has_exp      = 1'b1;
      e.exp.row_data = DATA_W'(exp_data);
      e.exp.moved    = exp_moved;
      return e;
   endfunction

   function automatic dir_entry_type csr_row(logic [CSR_INDEX_W-1:0] idx,
                                             logic [CSR_DATA_W-1:0] data);
      dir_entry_type e;
      e = '0;
      e.kind     = ENTRY_CSR;
      e.csr_idx  = idx;
      e.csr_data = data;
      return e;
   endfunction

   // Register write; caller drops csr_we after the last write of a batch
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx) inside
         CSR_SPRITE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
         CSR_BITMAP_0, CSR_BITMAP_1, CSR_BITMAP_2, CSR_BITMAP_3:
            bitmap_reg[idx - CSR_BITMAP_0] = data;
         default: ;
      endcase
   endtask

   // One request transfer, with an optional idle gap ahead of it
   task automatic send_item(input column_req_type item, input logic has_exp,
                            input column_result_type exp);
      int gap;
      column_result_type pred;
      gap = quiet_phase ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= item.op;
      req_chan.new_row   <= item.new_row;
      req_chan.force_req <= item.force_req;
      req_chan.read_row  <= item.read_row;
      do @(posedge clock); while (!req_chan.ready);
      pred = apply_column_item(item);
      pending_results.push_back(has_exp ? exp : pred);
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Response check and receiver stall pattern
   always @(posedge clock) begin : rsp_monitor
      column_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: row_data %02h moved %b",
                     $time, rsp_chan.row_data, rsp_chan.moved);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.row_data !== want.row_data) begin
               $display("%0t: row_data mismatch: expected %02h, actual %02h",
                        $time, want.row_data, rsp_chan.row_data);
               mismatch_count++;
            end
            if (rsp_chan.moved !== want.moved) begin
               $display("%0t: moved mismatch: expected %b, actual %b",
                        $time, want.moved, rsp_chan.moved);
               mismatch_count++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   initial begin : stimulus
      logic prev_csr;
      logic [HEIGHT_W-1:0] phase_height;
      int phase, b;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.op        <= OP_MOVE;
      req_chan.new_row   <= '0;
      req_chan.force_req <= 1'b0;
      req_chan.read_row  <= '0;
      foreach (column_img[i]) column_img[i] = '0;
      foreach (bitmap_reg[i]) bitmap_reg[i] = '0;
      sprite_top = '0;
      height_reg = '0;

      // Directed rows: reset state, skip/force, clipping at both ends, odd heights
      directed.push_back(checked_row(OP_READ, 0, 1'b0, 0, 0, 1'b0));
      directed.push_back(checked_row(OP_READ, 0, 1'b0, COLUMN_ROWS - 1, 0, 1'b0));
      directed.push_back(checked_row(OP_READ, 0, 1'b0, READ_ROW_MAX, 0, 1'b0));
      directed.push_back(checked_row(OP_MOVE, 0, 1'b0, 0, 0, 1'b0));
      directed.push_back(checked_row(OP_MOVE, 0, 1'b1, 0, 0, 1'b1));
      directed.push_back(checked_row(OP_MOVE, 10, 1'b0, 0, 0, 1'b1));
      directed.push_back(checked_row(OP_MOVE, 10, 1'b0, 0, 0, 1'b0));
      directed.push_back(csr_row(CSR_SPRITE_HEIGHT, CSR_DATA_W'(HEIGHT_MAX)));
      directed.push_back(csr_row(CSR_BITMAP_0, 64'h0807_0605_0403_0201));
      directed.push_back(csr_row(CSR_BITMAP_1, 64'h100f_0e0d_0c0b_0a09));
      directed.push_back(csr_row(CSR_BITMAP_2, 64'h1817_1615_1413_1211));
      directed.push_back(csr_row(CSR_BITMAP_3, 64'hff1f_1e1d_1c1b_1a19));
      directed.push_back(csr_row(CSR_INDEX_TOP, '1));
      directed.push_back(item_row(OP_MOVE, -128, 1'b0, 0));
      directed.push_back(item_row(OP_MOVE, 127, 1'b0, 0));
      directed.push_back(item_row(OP_MOVE, -31, 1'b0, 0));
      directed.push_back(item_row(OP_READ, 0, 1'b0, 0));
      directed.push_back(item_row(OP_MOVE, 64, 1'b0, 0));
      directed.push_back(item_row(OP_READ, 0, 1'b0, COLUMN_ROWS - 1));
      directed.push_back(item_row(OP_MOVE, 80, 1'b0, 0));
      directed.push_back(item_row(OP_READ, 0, 1'b0, COLUMN_ROWS - 1));
      directed.push_back(item_row(OP_MOVE, 80, 1'b1, 0));
      directed.push_back(checked_row(OP_READ, 0, 1'b0, READ_ROW_MAX, 0, 1'b0));
      directed.push_back(csr_row(CSR_SPRITE_HEIGHT, CSR_DATA_W'(1)));
      directed.push_back(item_row(OP_MOVE, 0, 1'b0, 0));
      directed.push_back(item_row(OP_READ, 0, 1'b0, 81));
      directed.push_back(item_row(OP_READ, 0, 1'b0, 80));
      directed.push_back(csr_row(CSR_SPRITE_HEIGHT, CSR_DATA_W'(0)));
      directed.push_back(checked_row(OP_MOVE, 5, 1'b0, 0, 0, 1'b1));
      directed.push_back(item_row(OP_READ, 0, 1'b0, 0));
      directed.push_back(csr_row(CSR_SPRITE_HEIGHT, CSR_DATA_W'(MAX_SPRITE_ROWS)));
      directed.push_back(item_row(OP_MOVE, 95, 1'b0, 0));
      directed.push_back(item_row(OP_READ, 0, 1'b0, COLUMN_ROWS - 1));
      directed.push_back(item_row(OP_MOVE, -1, 1'b0, 0));
      directed.push_back(item_row(OP_READ, 0, 1'b0, 30));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; register writes only with nothing in flight
      prev_csr = 1'b0;
      foreach (directed[i]) begin
         if (directed[i].kind == ENTRY_CSR) begin
            if (!prev_csr)
               drain_results();
            write_csr(directed[i].csr_idx, directed[i].csr_data);
            prev_csr = 1'b1;
         end else begin
            if (prev_csr)
               csr_we <= 1'b0;
            send_item(directed[i].req, directed[i].has_exp, directed[i].exp);
            prev_csr = 1'b0;
         end
      end

      // Random phases, each with a fresh register setting
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         quiet_phase = (phase % 4 == 1);
         case (phase)
            0:       phase_height = '0;
            1:       phase_height = HEIGHT_W'(MAX_SPRITE_ROWS);
            2:       phase_height = HEIGHT_W'(HEIGHT_MAX);
            default: phase_height = HEIGHT_W'($urandom_range(0, HEIGHT_MAX));
         endcase
         write_csr(CSR_SPRITE_HEIGHT, CSR_DATA_W'(phase_height));
         for (b = 0; b < BITMAP_REGS; b++) begin
            if (phase == 3)
               write_csr(CSR_INDEX_W'(CSR_BITMAP_0 + b), '1);
            else
               write_csr(CSR_INDEX_W'(CSR_BITMAP_0 + b), {$urandom, $urandom});
         end
         if (phase % 2 == 1)
            write_csr(CSR_INDEX_W'($urandom_range(CSR_BITMAP_3 + 1, CSR_INDEX_TOP)),
                      {$urandom, $urandom});
         csr_we <= 1'b0;
         repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
      end

      drain_results();
      quiet_phase = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("** sprite_column_move_with_clipping: PASSED **");
      else
         $display("** sprite_column_move_with_clipping: FAILED **");
      $finish;
   end

endmodule
